/* hdl/dsp_pkg.sv */
// Shared types, constants and the half-step coil table for the dual stepper positioner.
// No dependencies; every other file in this folder depends on it.
package dsp_pkg;

    localparam int DEF_ANGLE_BITS = 21;

    localparam int STEP_BITS     = 10;
    localparam int TOL_BITS      = 14;
    localparam int CFG_DATA_BITS = 14;
    localparam int CFG_IDX_BITS  = 1;
    localparam int PHASE_BITS    = 3;
    localparam int COIL_BITS     = 4;

    localparam logic [STEP_BITS-1:0] STEP_SIZE_RESET = STEP_BITS'(88);
    localparam logic [TOL_BITS-1:0]  TOLERANCE_RESET = TOL_BITS'(100);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 1'b1;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_size;
        logic [TOL_BITS-1:0]  tolerance;
    } cfg_t;

    // per-axis status after one step
    typedef struct packed {
        logic near;    // within the arrival window
        logic past;    // position magnitude beyond goal magnitude
    } axis_flags_t;

    // half-step coil pattern, bit0 = first coil
    function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [PHASE_BITS-1:0] phase);
        logic [COIL_BITS-1:0] pat;
        unique case (phase)
            3'd0: pat = 4'b0001;
            3'd1: pat = 4'b0011;
            3'd2: pat = 4'b0010;
            3'd3: pat = 4'b0110;
            3'd4: pat = 4'b0100;
            3'd5: pat = 4'b1100;
            3'd6: pat = 4'b1000;
            3'd7: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

/* hdl/dsp_channels.sv */
// Valid/ready channel interfaces for the request and result sides of the positioner.
// Depends on dsp_pkg.
interface dsp_cmd_if #(
    parameter int ANGLE_BITS = dsp_pkg::DEF_ANGLE_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [ANGLE_BITS-1:0] hori_target;
    logic signed [ANGLE_BITS-1:0] vert_target;

    modport source (output valid, op, hori_target, vert_target, input ready);
    modport sink   (input valid, op, hori_target, vert_target, output ready);
endinterface

interface dsp_rsp_if #(
    parameter int ANGLE_BITS = dsp_pkg::DEF_ANGLE_BITS
);
    logic                         valid;
    logic                         ready;
    logic [dsp_pkg::COIL_BITS-1:0] hori_coils;
    logic [dsp_pkg::COIL_BITS-1:0] vert_coils;
    logic signed [ANGLE_BITS-1:0] hori_position;
    logic signed [ANGLE_BITS-1:0] vert_position;
    logic                         done_res;

    modport source (output valid, hori_coils, vert_coils, hori_position, vert_position,
                    done_res, input ready);
    modport sink   (input valid, hori_coils, vert_coils, hori_position, vert_position,
                    done_res, output ready);
endinterface

/* hdl/dsp_cfg_regs.sv */
// Configuration register file: step size and arrival tolerance.
// Depends on dsp_pkg.
module dsp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dsp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output dsp_pkg::cfg_t                     cfg
);
    import dsp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_SIZE: cfg_next.step_size = cfg_data[STEP_BITS-1:0];
                CFG_TOLERANCE: cfg_next.tolerance = cfg_data[TOL_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= STEP_SIZE_RESET;
            cfg_reg.tolerance <= TOLERANCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/dsp_axis.sv */
// One axis half-step: direction, saturating position update, phase wrap and arrival tests.
// Depends on dsp_pkg.
module dsp_axis #(
    parameter int ANGLE_BITS = dsp_pkg::DEF_ANGLE_BITS
) (
    input  logic signed [ANGLE_BITS-1:0]       angle,
    input  logic signed [ANGLE_BITS-1:0]       goal,
    input  logic [dsp_pkg::PHASE_BITS-1:0]     phase,
    input  dsp_pkg::cfg_t                      cfg,
    output logic signed [ANGLE_BITS-1:0]       angle_next,
    output logic [dsp_pkg::PHASE_BITS-1:0]     phase_next,
    output dsp_pkg::axis_flags_t               flags
);
    import dsp_pkg::*;

    localparam int W1 = ANGLE_BITS + 1;
    localparam int W2 = ANGLE_BITS + 2;

    logic                 below;
    logic                 above;
    logic signed [W1-1:0] angle_w;
    logic signed [W1-1:0] step_w;
    logic signed [W1-1:0] sum_w;
    logic signed [W2-1:0] diff_w;
    logic [W2-1:0]        diff_mag;
    logic [W1-1:0]        angle_mag;
    logic [W1-1:0]        goal_mag;
    logic signed [W1-1:0] new_w;
    logic signed [W1-1:0] goal_w;

    assign below   = angle < goal;
    assign above   = angle > goal;
    assign angle_w = W1'(angle);
    assign goal_w  = W1'(goal);
    assign step_w  = $signed(W1'(cfg.step_size));
    assign sum_w   = below ? angle_w + step_w : angle_w - step_w;

    always_comb
    begin
        priority if (!below && !above)
            angle_next = angle;
        else if (sum_w[W1-1] != sum_w[W1-2])
            // clamp to the range limit on the side of the true sign
            angle_next = sum_w[W1-1] ? {1'b1, {(ANGLE_BITS-1){1'b0}}}
                                     : {1'b0, {(ANGLE_BITS-1){1'b1}}};
        else
            angle_next = sum_w[ANGLE_BITS-1:0];
    end

    always_comb
    begin
        priority if (below)
            phase_next = phase + PHASE_BITS'(1);
        else if (above)
            phase_next = phase - PHASE_BITS'(1);
        else
            phase_next = phase;
    end

    assign new_w     = W1'(angle_next);
    assign diff_w    = W2'(new_w) - W2'(goal_w);
    assign diff_mag  = diff_w[W2-1] ? W2'(-diff_w) : W2'(diff_w);
    assign angle_mag = new_w[W1-1] ? W1'(-new_w) : W1'(new_w);
    assign goal_mag  = goal_w[W1-1] ? W1'(-goal_w) : W1'(goal_w);

    assign flags.near = diff_mag < W2'(cfg.tolerance);
    assign flags.past = angle_mag > goal_mag;

endmodule

/* hdl/dual_stepper_half_step_positioner.sv */
// Top level of the dual half-step stepper positioner: state, result register and handshake.
// Depends on dsp_pkg, dsp_channels, dsp_cfg_regs and dsp_axis.
//
//   channel  | dir | payload                                            | handshake
//   ---------+-----+----------------------------------------------------+-------------
//   cmd      | in  | op, hori_target, vert_target                       | valid/ready
//   rsp      | out | hori_coils, vert_coils, hori/vert_position, done_res | valid/ready
//   cfg      | in  | cfg_index, cfg_data                                | cfg_we only
//
// Every request yields one result, valid in the cycle after acceptance; a new request can be
// taken every cycle. The single result register sets that figure: cmd.ready drops only
// while a result waits and rsp.ready is low. Reset clears the targets and positions,
// puts both phases at zero, marks the move done and loads step size 88, tolerance 100.
module dual_stepper_half_step_positioner #(
    parameter int ANGLE_BITS = dsp_pkg::DEF_ANGLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dsp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    dsp_cmd_if.sink                           cmd,
    dsp_rsp_if.source                         rsp
);
    import dsp_pkg::*;

    cfg_t cfg;

    // move state
    logic [PHASE_BITS-1:0]        hori_phase_reg, hori_phase_next;
    logic [PHASE_BITS-1:0]        vert_phase_reg, vert_phase_next;
    logic signed [ANGLE_BITS-1:0] hori_angle_reg, hori_angle_next;
    logic signed [ANGLE_BITS-1:0] vert_angle_reg, vert_angle_next;
    logic signed [ANGLE_BITS-1:0] hori_goal_reg, hori_goal_next;
    logic signed [ANGLE_BITS-1:0] vert_goal_reg, vert_goal_next;
    logic                         finished_reg, finished_next;

    // result register
    logic                         rsp_valid_reg, rsp_valid_next;
    logic [COIL_BITS-1:0]         hori_coils_reg, vert_coils_reg;
    logic signed [ANGLE_BITS-1:0] hori_pos_reg, vert_pos_reg;
    logic                         done_reg;

    // stepped values from the axis units
    logic signed [ANGLE_BITS-1:0] hori_step_angle, vert_step_angle;
    logic [PHASE_BITS-1:0]        hori_step_phase, vert_step_phase;
    axis_flags_t                  hori_flags, vert_flags;

    logic accept;

    dsp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsp_axis #(.ANGLE_BITS(ANGLE_BITS)) u_hori (
        .angle      (hori_angle_reg),
        .goal       (hori_goal_reg),
        .phase      (hori_phase_reg),
        .cfg        (cfg),
        .angle_next (hori_step_angle),
        .phase_next (hori_step_phase),
        .flags      (hori_flags)
    );

    dsp_axis #(.ANGLE_BITS(ANGLE_BITS)) u_vert (
        .angle      (vert_angle_reg),
        .goal       (vert_goal_reg),
        .phase      (vert_phase_reg),
        .cfg        (cfg),
        .angle_next (vert_step_angle),
        .phase_next (vert_step_phase),
        .flags      (vert_flags)
    );

    // Take a request whenever the result slot is empty or is being drained.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        hori_phase_next = hori_phase_reg;
        vert_phase_next = vert_phase_reg;
        hori_angle_next = hori_angle_reg;
        vert_angle_next = vert_angle_reg;
        hori_goal_next  = hori_goal_reg;
        vert_goal_next  = vert_goal_reg;
        finished_next   = finished_reg;
        if (accept)
        begin
            priority if (cmd.op == OP_LOAD)
            begin
                // start a move: latch targets, zero positions, keep phases
                hori_goal_next  = cmd.hori_target;
                vert_goal_next  = cmd.vert_target;
                hori_angle_next = '0;
                vert_angle_next = '0;
                finished_next   = 1'b0;
            end
            else if (!finished_reg)
            begin
                // advance both axes one half-step, then test for arrival
                hori_angle_next = hori_step_angle;
                vert_angle_next = vert_step_angle;
                hori_phase_next = hori_step_phase;
                vert_phase_next = vert_step_phase;
                finished_next   = (hori_flags.near && vert_flags.near)
                               || (hori_flags.past && vert_flags.past);
            end
            else
            begin
                // finished move: hold everything, result repeats current state
                finished_next = finished_reg;
            end
        end
    end

    always_comb
    begin
        priority if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hori_phase_reg <= '0;
            vert_phase_reg <= '0;
            hori_angle_reg <= '0;
            vert_angle_reg <= '0;
            hori_goal_reg  <= '0;
            vert_goal_reg  <= '0;
            finished_reg   <= 1'b1;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            hori_phase_reg <= hori_phase_next;
            vert_phase_reg <= vert_phase_next;
            hori_angle_reg <= hori_angle_next;
            vert_angle_reg <= vert_angle_next;
            hori_goal_reg  <= hori_goal_next;
            vert_goal_reg  <= vert_goal_next;
            finished_reg   <= finished_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Result payload: capture the post-request state on every accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hori_coils_reg <= coil_pattern(hori_phase_next);
            vert_coils_reg <= coil_pattern(vert_phase_next);
            hori_pos_reg   <= hori_angle_next;
            vert_pos_reg   <= vert_angle_next;
            done_reg       <= finished_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hori_coils    = hori_coils_reg;
    assign rsp.vert_coils    = vert_coils_reg;
    assign rsp.hori_position = hori_pos_reg;
    assign rsp.vert_position = vert_pos_reg;
    assign rsp.done_res      = done_reg;

    // A load always reports an unfinished move at position zero.
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.op == OP_LOAD |=> rsp.valid && !rsp.done_res
            && rsp.hori_position == '0 && rsp.vert_position == '0)
        else $error("load result not at zero or marked done");

    // A finished move stays finished until the next load.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg && !(accept && cmd.op == OP_LOAD) |=> finished_reg)
        else $error("finished move restarted without a load");

    // The phase moves by at most one half-step per cycle.
    a_hori_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> hori_phase_reg == $past(hori_phase_reg)
            || hori_phase_reg == PHASE_BITS'($past(hori_phase_reg) + PHASE_BITS'(1))
            || hori_phase_reg == PHASE_BITS'($past(hori_phase_reg) - PHASE_BITS'(1)))
        else $error("horizontal phase jumped");

    // A stalled result blocks new requests so nothing is overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |-> !cmd.ready)
        else $error("request accepted over a pending result");

endmodule
